// ----- design/hps_pkg.sv -----
// Shared types and constants for the HDR pixel sanitizer.
package hps_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned LIMIT_W = 31;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'h477D_E800;
	localparam logic [WORD_W-1:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [7:0] EXP_ONES = 8'hFF;

	// What one colour lane found for its channel.
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              nonfinite;
		logic              negative;
		logic              clamped;
		logic              cand_valid;
		logic [WORD_W-2:0] cand;
	} lane_res_t;

endpackage

// ----- design/hps_lane.sv -----
// One colour channel lane: classification and cleaning of a binary32 value.
module hps_lane (
	input  logic [hps_pkg::WORD_W-1:0]  x,
	input  logic [hps_pkg::LIMIT_W-1:0] limit,
	output hps_pkg::lane_res_t          res
);

	// Classify on the bit pattern alone.
	always_comb begin
		res = '0;
		res.cand = x[hps_pkg::WORD_W-2:0];
		if (x[30:23] == hps_pkg::EXP_ONES) begin
			res.nonfinite = 1'b1;
			res.value = '0;
		end else if (x[31]) begin
			res.negative = (x[30:0] != '0);
			res.value = res.negative ? '0 : x;
		end else begin
			res.cand_valid = 1'b1;
			if (x[30:0] > limit) begin
				res.clamped = 1'b1;
				res.value = {1'b0, limit};
			end else begin
				res.value = x;
			end
		end
	end

endmodule

// ----- design/hps_merge.sv -----
// Merging stage: statistics counters and running maximum over the lanes.
module hps_merge #(
	parameter int unsigned COUNT_WIDTH = hps_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       clear,
	input  hps_pkg::lane_res_t [2:0]   lanes,
	output logic [hps_pkg::WORD_W-1:0] nonfinite_total,
	output logic [hps_pkg::WORD_W-1:0] negative_total,
	output logic [hps_pkg::WORD_W-1:0] clamped_total,
	output logic [hps_pkg::WORD_W-1:0] max_total
);

	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [COUNT_WIDTH-1:0] nf_q, ng_q, cl_q, nf_d, ng_d, cl_d;
	logic [hps_pkg::WORD_W-2:0] mx_q, mx_d;

	// Saturating add of up to three events.
	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] c, input logic [1:0] n);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, c} + {{(COUNT_WIDTH-1){1'b0}}, n};
		return s[COUNT_WIDTH] ? CMAX : s[COUNT_WIDTH-1:0];
	endfunction

	// Next statistics after this word.
	always_comb begin
		logic [COUNT_WIDTH-1:0] nf0, ng0, cl0;
		nf0 = clear ? '0 : nf_q;
		ng0 = clear ? '0 : ng_q;
		cl0 = clear ? '0 : cl_q;
		mx_d = clear ? '0 : mx_q;
		nf_d = sat_add(nf0, 2'(lanes[0].nonfinite) + 2'(lanes[1].nonfinite)
			+ 2'(lanes[2].nonfinite));
		ng_d = sat_add(ng0, 2'(lanes[0].negative) + 2'(lanes[1].negative)
			+ 2'(lanes[2].negative));
		cl_d = sat_add(cl0, 2'(lanes[0].clamped) + 2'(lanes[1].clamped)
			+ 2'(lanes[2].clamped));
		for (int i = 0; i < 3; i++) begin
			if (lanes[i].cand_valid && lanes[i].cand > mx_d) begin
				mx_d = lanes[i].cand;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q <= '0;
			ng_q <= '0;
			cl_q <= '0;
			mx_q <= '0;
		end else if (step) begin
			nf_q <= nf_d;
			ng_q <= ng_d;
			cl_q <= cl_d;
			mx_q <= mx_d;
		end
	end

	// Narrow or cap counters to the output word.
	function automatic logic [hps_pkg::WORD_W-1:0] out_cnt(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_WIDTH+hps_pkg::WORD_W-1:0] w;
		w = {{hps_pkg::WORD_W{1'b0}}, c};
		if (COUNT_WIDTH > hps_pkg::WORD_W && (w >> hps_pkg::WORD_W) != '0) begin
			return '1;
		end
		return w[hps_pkg::WORD_W-1:0];
	endfunction

	assign nonfinite_total = out_cnt(nf_q);
	assign negative_total  = out_cnt(ng_q);
	assign clamped_total   = out_cnt(cl_q);
	assign max_total       = {1'b0, mx_q};

endmodule

// ----- design/hdr_pixel_sanitizer.sv -----
// Top level of the HDR pixel sanitizer: lanes, merge and output register.
// One pixel is taken every cycle unless the output stalls; its result is
// captured in the output register on the next clock, with statistics read
// straight from the merge counters. Three colour lanes and the alpha path
// work side by side, and the merge updates the counters in the same cycle.
// It accepts a word whenever the output register is empty or being taken.
module hdr_pixel_sanitizer #(
	parameter int unsigned COUNT_WIDTH = hps_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [30:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// red_in, green_in, blue_in, alpha_in
	input  logic [127:0] s_tdata,
	// start_of_image
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// red, green, blue, alpha, nonfinite, negative, clamped, max_finite_value
	output logic [255:0] m_tdata
);

	logic [hps_pkg::LIMIT_W-1:0] limit_q;
	hps_pkg::lane_res_t [2:0] lanes;
	logic [31:0] alpha, a_in, nf, ng, cl, mx;
	logic step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hps_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign s_tready = !m_tvalid || m_tready;
	assign step = s_tvalid && s_tready;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		hps_lane u_lane (.x(s_tdata[32*g +: 32]), .limit(limit_q), .res(lanes[g]));
	end

	// Alpha clamp to the unit range.
	assign a_in = s_tdata[127:96];
	always_comb begin
		if (a_in[30:23] == hps_pkg::EXP_ONES) begin
			alpha = hps_pkg::ONE_BITS;
		end else if (a_in[31]) begin
			alpha = (a_in[30:0] != '0) ? '0 : a_in;
		end else begin
			alpha = (a_in > hps_pkg::ONE_BITS) ? hps_pkg::ONE_BITS : a_in;
		end
	end

	hps_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge (
		.clk(clk), .arst_n(arst_n), .step(step), .clear(s_tuser), .lanes(lanes),
		.nonfinite_total(nf), .negative_total(ng), .clamped_total(cl), .max_total(mx)
	);

	logic [127:0] pix_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (step) begin
			pix_q <= {alpha, lanes[2].value, lanes[1].value, lanes[0].value};
		end
	end
	assign m_tdata = {mx, cl, ng, nf, pix_q};

	// A word waiting downstream must not be overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(pix_q))
		else $error("output word lost");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stalled while empty");
	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[255]) else $error("negative maximum");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the HDR pixel sanitizer stream block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
	localparam logic [31:0] POS_INF = 32'h7F80_0000;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;
	localparam logic [31:0] MINUS_ZERO = 32'h8000_0000;
	localparam logic [31:0] MAX_FINITE = 32'h7F7F_FFFF;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        sop;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] g;
		logic [31:0] r;
	} pixel_t;

	typedef struct packed {
		logic [31:0] peak;
		logic [31:0] clamped;
		logic [31:0] negative;
		logic [31:0] nonfinite;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] g;
		logic [31:0] r;
	} clean_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [30:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	// red_in, green_in, blue_in, alpha_in
	logic [127:0] s_tdata;
	// start_of_image
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// red, green, blue, alpha, nonfinite, negative, clamped, max_finite_value
	logic [255:0] m_tdata;

	pixel_t pending_pixels[$];
	clean_t expected_pixels[$];
	int     mismatches;
	bit     hold_off;
	int     burst_left;
	int     gap_left;

	// Predictor state
	logic [30:0] limit_bits;
	logic [31:0] nonfinite_cnt, negative_cnt, clamped_cnt, peak_val;

	hdr_pixel_sanitizer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_up(logic [31:0] c);
		return (c == ALL_ONES) ? c : c + 32'd1;
	endfunction

	// Cleans one colour channel and updates the running statistics.
	function automatic logic [31:0] sanitize_colour(logic [31:0] x);
		if ((x & EXP_MASK) == EXP_MASK) begin
			nonfinite_cnt = sat_up(nonfinite_cnt);
			return 32'd0;
		end
		if (!x[31] && x > peak_val)
			peak_val = x;
		if (x[31]) begin
			if (x[30:0] != 31'd0) begin
				negative_cnt = sat_up(negative_cnt);
				return 32'd0;
			end
			return x;
		end
		if (x > {1'b0, limit_bits}) begin
			clamped_cnt = sat_up(clamped_cnt);
			return {1'b0, limit_bits};
		end
		return x;
	endfunction

	function automatic logic [31:0] sanitize_alpha(logic [31:0] x);
		if ((x & EXP_MASK) == EXP_MASK)
			return hps_pkg::ONE_BITS;
		if (x[31])
			return (x[30:0] != 31'd0) ? 32'd0 : x;
		return (x > hps_pkg::ONE_BITS) ? hps_pkg::ONE_BITS : x;
	endfunction

	function automatic clean_t predict_pixel(pixel_t p);
		clean_t e;
		if (p.sop) begin
			nonfinite_cnt = '0;
			negative_cnt = '0;
			clamped_cnt = '0;
			peak_val = '0;
		end
		e.r = sanitize_colour(p.r);
		e.g = sanitize_colour(p.g);
		e.b = sanitize_colour(p.b);
		e.a = sanitize_alpha(p.a);
		e.nonfinite = nonfinite_cnt;
		e.negative = negative_cnt;
		e.clamped = clamped_cnt;
		e.peak = peak_val;
		return e;
	endfunction

	// Random binary32 pattern biased toward interesting classes.
	function automatic logic [31:0] random_float();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:0] = 31'd0;
			3: v = {$urandom_range(0, 1) == 1, 8'($urandom_range(8'h7C, 8'h80)), v[22:0]};
			4: v = {1'b0, 8'($urandom_range(8'h8C, 8'h90)), v[22:0]};
			default: v[31] = ($urandom_range(0, 3) == 0);
		endcase
		return v;
	endfunction

	task automatic queue_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
			logic [31:0] a, logic sop);
		pixel_t p;
		p = '{sop: sop, a: a, b: b, g: g, r: r};
		pending_pixels.insert(pending_pixels.size(), p);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			queue_pixel(random_float(), random_float(), random_float(), random_float(),
				$urandom_range(0, 40) == 0);
	endtask

	// Waits for the stream to drain, then writes the limit register.
	task automatic set_limit(logic [30:0] lim);
		wait (pending_pixels.size() == 0 && expected_pixels.size() == 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_bits = lim;
	endtask

	// Driver: bursts of words separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_pixels.insert(expected_pixels.size(),
					predict_pixel(pending_pixels.pop_front()));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_pixels[0].a, pending_pixels[0].b,
						pending_pixels[0].g, pending_pixels[0].r};
					s_tuser <= pending_pixels[0].sop;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Monitor: compares each accepted word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			clean_t got, want;
			got = m_tdata;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output word %h", got);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_off = 1'b0;
		mismatches = 0;
		limit_bits = hps_pkg::LIMIT_RESET;
		nonfinite_cnt = '0;
		negative_cnt = '0;
		clamped_cnt = '0;
		peak_val = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: special values per channel at the reset limit.
		queue_pixel(POS_INF, QNAN, 32'hFF80_0000, POS_INF, 1'b1);
		queue_pixel(MINUS_ZERO, 32'hBF80_0000, 32'h0000_0001, MINUS_ZERO, 1'b0);
		queue_pixel(MAX_FINITE, 32'h477D_E801, 32'h477D_E800, 32'h3F80_0001, 1'b0);
		queue_pixel(32'd0, 32'h807F_FFFF, 32'h3F80_0000, 32'h8000_0001, 1'b0);
		queue_pixel(ALL_ONES, 32'h7FFF_FFFF, 32'h0080_0000, 32'h3F00_0000, 1'b0);
		queue_pixel(32'h4000_0000, 32'd0, 32'd0, 32'h0000_0001, 1'b1);
		queue_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, ALL_ONES, 1'b0);
		queue_random(150);

		// Zero limit: every positive value clamps.
		set_limit(31'd0);
		queue_pixel(32'h0000_0001, MINUS_ZERO, 32'h3F80_0000, 32'd0, 1'b1);
		queue_random(150);

		// Infinity and NaN limits: nothing finite is clamped.
		set_limit(31'h7F80_0000);
		queue_pixel(MAX_FINITE, 32'h7F7F_FFFE, 32'd1, 32'd0, 1'b0);
		queue_random(120);
		set_limit(31'h7FFF_FFFF);
		queue_pixel(MAX_FINITE, POS_INF, 32'd1, 32'd0, 1'b0);
		queue_random(100);

		// Mid limit, with a long receiver hold-off to back up the input.
		set_limit(31'h3F80_0000);
		queue_random(180);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;

		wait (pending_pixels.size() == 0 && expected_pixels.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
